@@ rtl/ldbq_pkg.sv @@
// Shared constants, command and result types, and state codes for the
// landmark distance bound query block. Depends on nothing else.
package ldbq_pkg;

    localparam int MAX_LANDMARKS = 16;
    localparam int MAX_NODES     = 1024;
    localparam int DIST_BITS     = 16;

    localparam int LM_BITS     = $clog2(MAX_LANDMARKS);
    localparam int NODE_BITS   = $clog2(MAX_NODES);
    localparam int ADDR_BITS   = LM_BITS + NODE_BITS;
    localparam int MEM_DEPTH   = MAX_LANDMARKS * MAX_NODES;
    localparam int SUM_BITS    = DIST_BITS + 1;
    localparam int COUNT_BITS  = 5;
    localparam int PROD_BITS   = SUM_BITS + DIST_BITS;
    localparam int ROOT_BITS   = (PROD_BITS + 1) / 2;
    localparam int RAD_BITS    = 2 * ROOT_BITS;
    localparam int REM_BITS    = ROOT_BITS + 2;
    localparam int STEP_BITS   = $clog2(ROOT_BITS + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    localparam logic [SUM_BITS-1:0]   UPPER_NONE  = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(4);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX   = COUNT_BITS'(MAX_LANDMARKS);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic {
        CMD_WRITE,
        CMD_QUERY
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t            kind;
        logic [LM_BITS-1:0]   lm;
        logic [NODE_BITS-1:0] node_a;
        logic [NODE_BITS-1:0] node_b;
        logic [DIST_BITS-1:0] distance;
    } cmd_t;

    typedef struct packed {
        logic [SUM_BITS-1:0]  upper;
        logic [DIST_BITS-1:0] lower;
        logic [SUM_BITS-1:0]  mid;
        logic [ROOT_BITS-1:0] gmean;
        logic                 found;
    } result_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SCAN,
        BK_MUL,
        BK_START,
        BK_ROOT,
        BK_DONE
    } back_state_t;

endpackage

@@ rtl/ldbq_if.sv @@
// Valid/ready channel interfaces for input items and result items.
// Depends on ldbq_pkg for the field widths.
interface ldbq_item_if;
    import ldbq_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 opcode;
    logic [LM_BITS-1:0]   landmark_index;
    logic [NODE_BITS-1:0] node_a;
    logic [NODE_BITS-1:0] node_b;
    logic [DIST_BITS-1:0] distance;

    modport source (output valid, opcode, landmark_index, node_a, node_b, distance,
                    input ready);
    modport sink (input valid, opcode, landmark_index, node_a, node_b, distance,
                  output ready);
endinterface

interface ldbq_result_if;
    import ldbq_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [SUM_BITS-1:0]  upper_bound;
    logic [DIST_BITS-1:0] lower_bound;
    logic [SUM_BITS-1:0]  midpoint;
    logic [ROOT_BITS-1:0] geometric_mean;
    logic                 upper_found;

    modport source (output valid, upper_bound, lower_bound, midpoint, geometric_mean,
                    upper_found, input ready);
    modport sink (input valid, upper_bound, lower_bound, midpoint, geometric_mean,
                  upper_found, output ready);
endinterface

@@ rtl/ldbq_front.sv @@
// Front end: accepts input beats, classifies them into write or query commands
// and offers them to the command queue. Depends on ldbq_pkg and ldbq_if.
module ldbq_front (
    input  logic           clk,
    input  logic           rst_n,
    ldbq_item_if.sink      item,
    output ldbq_pkg::cmd_t push_cmd,
    output logic           push_valid,
    input  logic           push_ready
);
    import ldbq_pkg::*;

    logic hold_valid_reg;
    logic hold_valid_next;
    cmd_t cmd_reg;
    cmd_t cmd_next;
    logic take;

    assign item.ready = !hold_valid_reg || push_ready;
    assign take       = item.valid && item.ready;
    assign push_valid = hold_valid_reg;
    assign push_cmd   = cmd_reg;

    always_comb
    begin
        cmd_next.kind     = (item.opcode == OP_QUERY) ? CMD_QUERY : CMD_WRITE;
        cmd_next.lm       = item.landmark_index;
        cmd_next.node_a   = item.node_a;
        cmd_next.node_b   = item.node_b;
        cmd_next.distance = item.distance;
        hold_valid_next   = take || (hold_valid_reg && !push_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

@@ rtl/ldbq_queue.sv @@
// Short command queue that decouples the front end from the back end.
// Depends on ldbq_pkg for the command type and depth.
module ldbq_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  ldbq_pkg::cmd_t push_cmd,
    input  logic           push_valid,
    output logic           push_ready,
    output ldbq_pkg::cmd_t pop_cmd,
    output logic           pop_valid,
    input  logic           pop_ready
);
    import ldbq_pkg::*;

    cmd_t                 entries [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_next;
    logic [QPTR_BITS:0]   count_reg;
    logic [QPTR_BITS:0]   count_next;
    logic                 do_push;
    logic                 do_pop;

    assign push_ready = (count_reg != (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entries[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ rtl/ldbq_isqrt.sv @@
// Iterative floor square root, two radicand bits per cycle.
// Depends on ldbq_pkg for the radicand and root widths.
module ldbq_isqrt (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [ldbq_pkg::RAD_BITS-1:0]  radicand,
    output logic                           done,
    output logic [ldbq_pkg::ROOT_BITS-1:0] root
);
    import ldbq_pkg::*;

    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [STEP_BITS-1:0] step_reg;
    logic [STEP_BITS-1:0] step_next;
    logic [RAD_BITS-1:0]  rad_reg;
    logic [REM_BITS-1:0]  rem_reg;
    logic [REM_BITS-1:0]  rem_step;
    logic [ROOT_BITS-1:0] root_reg;
    logic [ROOT_BITS-1:0] root_step;
    logic [REM_BITS+1:0]  shifted;
    logic [REM_BITS+1:0]  trial;

    assign done = done_reg;
    assign root = root_reg;

    always_comb
    begin
        shifted   = {rem_reg, rad_reg[RAD_BITS-1 -: 2]};
        trial     = {2'b00, root_reg, 2'b01};
        if (shifted >= trial)
        begin
            rem_step  = REM_BITS'(shifted - trial);
            root_step = {root_reg[ROOT_BITS-2:0], 1'b1};
        end
        else
        begin
            rem_step  = shifted[REM_BITS-1:0];
            root_step = {root_reg[ROOT_BITS-2:0], 1'b0};
        end
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_BITS'(ROOT_BITS);
        end
        else if (busy_reg)
        begin
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[RAD_BITS-3:0], 2'b00};
            rem_reg  <= rem_step;
            root_reg <= root_step;
        end
    end

endmodule

@@ rtl/ldbq_back.sv @@
// Back end: distance memory, landmark scan, product and root sequencing, and the
// result register. Depends on ldbq_pkg, ldbq_if and ldbq_isqrt.
module ldbq_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ldbq_pkg::cmd_t                  pop_cmd,
    input  logic                            pop_valid,
    output logic                            pop_ready,
    input  logic [ldbq_pkg::COUNT_BITS-1:0] landmark_count,
    ldbq_result_if.source                   result
);
    import ldbq_pkg::*;

    logic [DIST_BITS-1:0]  dist_mem [MEM_DEPTH];
    back_state_t           state_reg;
    back_state_t           state_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic [COUNT_BITS-1:0] issue_reg;
    logic [COUNT_BITS-1:0] issue_next;
    logic                  rd_valid_reg;
    logic                  rd_valid_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [DIST_BITS-1:0]  rd_a_reg;
    logic [DIST_BITS-1:0]  rd_b_reg;
    logic [NODE_BITS-1:0]  node_a_reg;
    logic [NODE_BITS-1:0]  node_b_reg;
    logic [DIST_BITS-1:0]  lower_reg;
    logic [SUM_BITS-1:0]   upper_reg;
    logic                  found_reg;
    logic [PROD_BITS-1:0]  prod_reg;
    logic [SUM_BITS-1:0]   mid_reg;
    result_t               res_reg;
    logic [COUNT_BITS-1:0] count_sat;
    logic [LM_BITS-1:0]    rd_lm;
    logic [DIST_BITS-1:0]  diff;
    logic [SUM_BITS-1:0]   sum;
    logic [SUM_BITS:0]     mid_sum;
    logic                  mem_we;
    logic                  start_query;
    logic                  load_out;
    logic                  root_start;
    logic                  root_done;
    logic [ROOT_BITS-1:0]  root_val;

    assign count_sat = (landmark_count > COUNT_MAX) ? COUNT_MAX : landmark_count;
    assign rd_lm     = issue_reg[LM_BITS-1:0];
    assign diff      = (rd_b_reg >= rd_a_reg) ? rd_b_reg - rd_a_reg : rd_a_reg - rd_b_reg;
    assign sum       = {1'b0, rd_a_reg} + {1'b0, rd_b_reg};
    assign mid_sum   = {1'b0, upper_reg} + {2'b00, lower_reg};

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        issue_next    = issue_reg;
        rd_valid_next = 1'b0;
        pop_ready     = 1'b0;
        mem_we        = 1'b0;
        start_query   = 1'b0;
        load_out      = 1'b0;
        root_start    = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    case (pop_cmd.kind)
                        CMD_WRITE:
                        begin
                            mem_we = 1'b1;
                        end
                        CMD_QUERY:
                        begin
                            start_query = 1'b1;
                            count_next  = count_sat;
                            issue_next  = '0;
                            state_next  = BK_SCAN;
                        end
                        default:
                        begin
                            mem_we = 1'b0;
                        end
                    endcase
                end
            end
            BK_SCAN:
            begin
                if (issue_reg < count_reg)
                begin
                    rd_valid_next = 1'b1;
                    issue_next    = issue_reg + 1'b1;
                end
                else if (!rd_valid_reg)
                begin
                    state_next = BK_MUL;
                end
            end
            BK_MUL:
            begin
                state_next = BK_START;
            end
            BK_START:
            begin
                root_start = 1'b1;
                state_next = BK_ROOT;
            end
            BK_ROOT:
            begin
                if (root_done)
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    load_out   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
        out_valid_next = load_out || (out_valid_reg && !result.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            count_reg     <= '0;
            issue_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issue_reg     <= issue_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            dist_mem[{pop_cmd.lm, pop_cmd.node_a}] <= pop_cmd.distance;
        end
        rd_a_reg <= dist_mem[{rd_lm, node_a_reg}];
        rd_b_reg <= dist_mem[{rd_lm, node_b_reg}];
    end

    always_ff @(posedge clk)
    begin
        if (start_query)
        begin
            node_a_reg <= pop_cmd.node_a;
            node_b_reg <= pop_cmd.node_b;
            lower_reg  <= '0;
            upper_reg  <= UPPER_NONE;
            found_reg  <= 1'b0;
        end
        else if (rd_valid_reg)
        begin
            if (diff > lower_reg)
            begin
                lower_reg <= diff;
            end
            if ((sum != '0) && (sum < upper_reg))
            begin
                upper_reg <= sum;
                found_reg <= 1'b1;
            end
        end
        if (state_reg == BK_MUL)
        begin
            prod_reg <= PROD_BITS'(upper_reg) * PROD_BITS'(lower_reg);
            mid_reg  <= mid_sum[SUM_BITS:1];
        end
        if (load_out)
        begin
            res_reg.upper <= upper_reg;
            res_reg.lower <= lower_reg;
            res_reg.mid   <= mid_reg;
            res_reg.gmean <= root_val;
            res_reg.found <= found_reg;
        end
    end

    ldbq_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (RAD_BITS'(prod_reg)),
        .done     (root_done),
        .root     (root_val)
    );

    assign result.valid          = out_valid_reg;
    assign result.upper_bound    = res_reg.upper;
    assign result.lower_bound    = res_reg.lower;
    assign result.midpoint       = res_reg.mid;
    assign result.geometric_mean = res_reg.gmean;
    assign result.upper_found    = res_reg.found;

endmodule

@@ rtl/landmark_distance_bound_query_top.sv @@
// Top level of the landmark distance bound query block: landmark count register,
// front end, command queue and back end. Depends on ldbq_pkg, ldbq_if, ldbq_front,
// ldbq_queue and ldbq_back.
// The item channel carries write beats (opcode 0), which store one landmark
// distance, and query beats (opcode 1), which name a source and a target node.
// Each query yields one beat on the result channel; writes yield none.
// The landmark count is written through cfg_we and cfg_wdata; the user must do so
// only while the block is idle, which the block itself does not enforce. Values
// above the landmark capacity saturate to it. A write beat is taken every cycle
// while the queue has room; it passes the front register and the queue and is
// stored in the distance memory when the back end is idle. A query passes the
// front register and the queue, then scans one landmark per cycle on the two read
// ports of the distance memory, forms the product in the BK_MUL state and runs the
// iterative root. The back end takes no new command, write or query, until the
// result of the current query is loaded into the result register.
// Reset clears the queue, the sequencer and the result valid flag and sets the
// landmark count to 4; the distance memory holds unknown data until written.
// When the receiver stalls, the result beat holds, the next query finishes
// into a waiting state and the queue and front register fill before the item
// channel drops ready.
module landmark_distance_bound_query_top (
    input  logic                            clk,
    input  logic                            rst_n,
    ldbq_item_if.sink                       item,
    ldbq_result_if.source                   result,
    input  logic                            cfg_we,
    input  logic [ldbq_pkg::COUNT_BITS-1:0] cfg_wdata
);
    import ldbq_pkg::*;

    logic [COUNT_BITS-1:0] landmark_count_reg;
    logic [COUNT_BITS-1:0] landmark_count_next;
    cmd_t                  push_cmd;
    logic                  push_valid;
    logic                  push_ready;
    cmd_t                  pop_cmd;
    logic                  pop_valid;
    logic                  pop_ready;

    assign landmark_count_next = cfg_we ? cfg_wdata : landmark_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            landmark_count_reg <= COUNT_RESET;
        end
        else
        begin
            landmark_count_reg <= landmark_count_next;
        end
    end

    ldbq_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .push_cmd   (push_cmd),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    ldbq_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cmd   (push_cmd),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_cmd    (pop_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    ldbq_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .pop_cmd        (pop_cmd),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .landmark_count (landmark_count_reg),
        .result         (result)
    );

endmodule

@@ rtl/ldbq_checker.sv @@
// Port-level checks on the result channel of the bound query block, and the
// bind that attaches them to the top level. Depends on ldbq_pkg.
module ldbq_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           valid,
    input logic                           ready,
    input logic [ldbq_pkg::SUM_BITS-1:0]  upper_bound,
    input logic [ldbq_pkg::DIST_BITS-1:0] lower_bound,
    input logic [ldbq_pkg::SUM_BITS-1:0]  midpoint,
    input logic [ldbq_pkg::ROOT_BITS-1:0] geometric_mean,
    input logic                           upper_found
);
    import ldbq_pkg::*;

    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !valid)
        else $error("result beat shown during reset");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(upper_bound) && $stable(lower_bound)
            && $stable(midpoint) && $stable(geometric_mean) && $stable(upper_found))
        else $error("stalled result beat changed");

    a_found_flag: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (upper_found == (upper_bound != UPPER_NONE)))
        else $error("upper_found disagrees with the upper bound");

    a_none_found: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !upper_found |-> (lower_bound == '0) && (geometric_mean == '0)
            && (midpoint == SUM_BITS'(UPPER_NONE >> 1)))
        else $error("result without a nonzero sum is inconsistent");

    a_mean_order: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> ({1'b0, geometric_mean} <= (ROOT_BITS+1)'(midpoint)))
        else $error("geometric mean exceeds the midpoint");

endmodule

bind landmark_distance_bound_query_top ldbq_checker u_ldbq_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .valid          (result.valid),
    .ready          (result.ready),
    .upper_bound    (result.upper_bound),
    .lower_bound    (result.lower_bound),
    .midpoint       (result.midpoint),
    .geometric_mean (result.geometric_mean),
    .upper_found    (result.upper_found)
);

@@ tb/tb_top.sv @@
// Self-checking testbench for landmark_distance_bound_query_top: drives write and query
// beats with random pacing and checks every result beat against a bound predictor or,
// for typed directed rows, a table value. Depends on ldbq_pkg, ldbq_if and the RTL of the block.
`timescale 1ns / 100ps

module tb_top;
    import ldbq_pkg::*;

    localparam int SETTLE_CYCLES = 64;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 62;
    localparam int PHASES        = 8;
    localparam int FIXED_PHASES  = 6;
    localparam int DIR_ROWS      = 21;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic                 op;
        logic [LM_BITS-1:0]   lm;
        logic [NODE_BITS-1:0] na;
        logic [NODE_BITS-1:0] nb;
        logic [DIST_BITS-1:0] distance;
        logic                 typed;
        result_t              res;
    } stim_row_t;

    typedef enum int {
        RX_STEADY,
        RX_COIN,
        RX_MOSTLY,
        RX_LONG
    } rx_mode_t;

    localparam result_t NO_BOUNDS       = '0;
    localparam result_t BOUNDS_NONE     = '{UPPER_NONE, 16'd0, 17'd65535, 17'd0, 1'b0};
    localparam result_t BOUNDS_FAR      = '{17'd65535, 16'd65535, 17'd65535, 17'd65535, 1'b1};
    localparam result_t BOUNDS_SELF_FAR = '{17'd131070, 16'd0, 17'd65535, 17'd0, 1'b1};

    localparam logic [COUNT_BITS-1:0] FIXED_COUNTS [FIXED_PHASES] =
        '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd4};

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [COUNT_BITS-1:0] cfg_wdata;

    ldbq_item_if   item_ch ();
    ldbq_result_if result_ch ();

    landmark_distance_bound_query_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    logic [DIST_BITS-1:0]  dist_shadow [MAX_LANDMARKS][MAX_NODES];
    bit                    dist_written [MAX_LANDMARKS][MAX_NODES];
    bit                    node_full [MAX_NODES];
    logic [NODE_BITS-1:0]  full_nodes [$];
    logic [COUNT_BITS-1:0] lm_count_shadow;
    result_t               pending_bounds [$];
    stim_row_t             dir_tab [DIR_ROWS];
    int                    mismatches   = 0;
    int                    idle_cycles  = 0;
    int                    burst_left   = 0;
    int                    nodes_filled = 0;
    bit                    valid_up     = 1'b0;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic result_t predict_bounds(input logic [NODE_BITS-1:0] src,
                                               input logic [NODE_BITS-1:0] dst);
        result_t               r;
        int unsigned           scan;
        logic [DIST_BITS-1:0]  ds;
        logic [DIST_BITS-1:0]  dt;
        logic [DIST_BITS-1:0]  gap;
        logic [SUM_BITS-1:0]   total;
        logic [SUM_BITS:0]     both;
        logic [PROD_BITS-1:0]  prod;
        logic [ROOT_BITS-1:0]  root;
        logic [ROOT_BITS-1:0]  trial;
        scan    = (lm_count_shadow > COUNT_MAX) ? MAX_LANDMARKS : int'(lm_count_shadow);
        r.upper = UPPER_NONE;
        r.lower = '0;
        r.found = 1'b0;
        for (int i = 0; i < scan; i++)
        begin
            ds  = dist_shadow[i][src];
            dt  = dist_shadow[i][dst];
            gap = (dt >= ds) ? dt - ds : ds - dt;
            if (gap > r.lower)
                r.lower = gap;
            total = SUM_BITS'(ds) + SUM_BITS'(dt);
            if (total != 0 && total < r.upper)
            begin
                r.upper = total;
                r.found = 1'b1;
            end
        end
        both  = {1'b0, r.upper} + (SUM_BITS + 1)'(r.lower);
        r.mid = both[SUM_BITS:1];
        prod  = PROD_BITS'(r.upper) * PROD_BITS'(r.lower);
        root  = '0;
        for (int b = ROOT_BITS - 1; b >= 0; b--)
        begin
            trial = root | (ROOT_BITS'(1) << b);
            if (RAD_BITS'(trial) * RAD_BITS'(trial) <= RAD_BITS'(prod))
                root = trial;
        end
        r.gmean = root;
        return r;
    endfunction

    function automatic logic [DIST_BITS-1:0] pick_distance();
        case ($urandom_range(0, 9))
            0, 1:    return '0;
            2:       return '1;
            3, 4:    return DIST_BITS'($urandom_range(1, 15));
            5:       return DIST_BITS'($urandom_range(65000, 65535));
            default: return DIST_BITS'($urandom);
        endcase
    endfunction

    task automatic lower_valid();
        if (valid_up)
        begin
            item_ch.valid <= 1'b0;
            valid_up = 1'b0;
        end
    endtask

    task automatic wait_drained();
        lower_valid();
        do @(posedge clk); while (pending_bounds.size() != 0);
    endtask

    task automatic send_beat(input stim_row_t row);
        bit all_set;
        int gap;
        item_ch.valid          <= 1'b1;
        item_ch.opcode         <= row.op;
        item_ch.landmark_index <= row.lm;
        item_ch.node_a         <= row.na;
        item_ch.node_b         <= row.nb;
        item_ch.distance       <= row.distance;
        valid_up = 1'b1;
        do @(posedge clk); while (item_ch.ready !== 1'b1);

        if (row.op == OP_WRITE)
        begin
            dist_shadow[row.lm][row.na]  = row.distance;
            dist_written[row.lm][row.na] = 1'b1;
            all_set = 1'b1;
            for (int i = 0; i < MAX_LANDMARKS; i++)
                all_set &= dist_written[i][row.na];
            if (all_set && !node_full[row.na])
            begin
                node_full[row.na] = 1'b1;
                full_nodes = {full_nodes, row.na};
            end
        end
        else if (row.typed)
            pending_bounds = {pending_bounds, row.res};
        else
            pending_bounds = {pending_bounds, predict_bounds(row.na, row.nb)};

        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 5);
            lower_valid();
            repeat (gap) @(posedge clk);
            if ($urandom_range(0, 59) == 0)
                wait_drained();
        end
    endtask

    task automatic run_phase(input int quota);
        stim_row_t            row;
        logic [NODE_BITS-1:0] node;
        bit                   blank;
        int                   first;
        int                   sent;
        int                   roll;
        sent = 0;
        while (sent < quota)
        begin
            roll = $urandom_range(0, 99);
            if (full_nodes.size() < 2 || roll < 10)
            begin
                // A fresh node gets an entry for every landmark so that any count can query it.
                node  = (nodes_filled == 0) ? NODE_BITS'(0) :
                        (nodes_filled == 1) ? {NODE_BITS{1'b1}} : NODE_BITS'($urandom);
                blank = ($urandom_range(0, 7) == 0);
                first = $urandom_range(0, MAX_LANDMARKS - 1);
                nodes_filled++;
                for (int i = 0; i < MAX_LANDMARKS; i++)
                begin
                    row          = '0;
                    row.op       = OP_WRITE;
                    row.lm       = LM_BITS'((first + i) % MAX_LANDMARKS);
                    row.na       = node;
                    row.nb       = NODE_BITS'($urandom);
                    row.distance = blank ? '0 : pick_distance();
                    send_beat(row);
                    sent++;
                end
            end
            else
            begin
                row          = '0;
                row.lm       = LM_BITS'($urandom);
                row.nb       = NODE_BITS'($urandom);
                row.distance = DIST_BITS'($urandom);
                if (roll < 30)
                begin
                    row.op       = OP_WRITE;
                    row.na       = (roll < 20) ? full_nodes[$urandom_range(0, full_nodes.size() - 1)]
                                               : NODE_BITS'($urandom);
                    row.distance = pick_distance();
                end
                else
                begin
                    row.op = OP_QUERY;
                    row.na = full_nodes[$urandom_range(0, full_nodes.size() - 1)];
                    row.nb = (roll < 40) ? row.na
                                         : full_nodes[$urandom_range(0, full_nodes.size() - 1)];
                end
                send_beat(row);
                sent++;
            end
        end
    endtask

    initial begin
        logic [COUNT_BITS-1:0] count;
        rst_n                  <= 1'b0;
        cfg_we                 <= 1'b0;
        cfg_wdata              <= '0;
        item_ch.valid          <= 1'b0;
        item_ch.opcode         <= OP_WRITE;
        item_ch.landmark_index <= '0;
        item_ch.node_a         <= '0;
        item_ch.node_b         <= '0;
        item_ch.distance       <= '0;
        lm_count_shadow = COUNT_RESET;

        // The opening rows run with the reset landmark count and read landmarks 0 to 3 only.
        dir_tab = '{
            '{OP_WRITE, 4'd0,  10'd0,    10'd0,    16'd0,      1'b0, NO_BOUNDS},
            '{OP_WRITE, 4'd1,  10'd0,    10'd1023, 16'd0,      1'b0, NO_BOUNDS},
            '{OP_WRITE, 4'd2,  10'd0,    10'd0,    16'd0,      1'b0, NO_BOUNDS},
            '{OP_WRITE, 4'd3,  10'd0,    10'd0,    16'd0,      1'b0, NO_BOUNDS},
            '{OP_QUERY, 4'd0,  10'd0,    10'd0,    16'd0,      1'b1, BOUNDS_NONE},
            '{OP_WRITE, 4'd0,  10'd1023, 10'd1023, 16'd65535,  1'b0, NO_BOUNDS},
            '{OP_WRITE, 4'd1,  10'd1023, 10'd0,    16'd65535,  1'b0, NO_BOUNDS},
            '{OP_WRITE, 4'd2,  10'd1023, 10'd0,    16'd65535,  1'b0, NO_BOUNDS},
            '{OP_WRITE, 4'd3,  10'd1023, 10'd0,    16'd65535,  1'b0, NO_BOUNDS},
            '{OP_QUERY, 4'd0,  10'd0,    10'd1023, 16'd0,      1'b1, BOUNDS_FAR},
            '{OP_QUERY, 4'd15, 10'd1023, 10'd1023, 16'd65535,  1'b1, BOUNDS_SELF_FAR},
            '{OP_QUERY, 4'd0,  10'd1023, 10'd0,    16'd0,      1'b1, BOUNDS_FAR},
            '{OP_WRITE, 4'd15, 10'd512,  10'd0,    16'h5555,   1'b0, NO_BOUNDS},
            '{OP_WRITE, 4'd15, 10'd1023, 10'd341,  16'hAAAA,   1'b0, NO_BOUNDS},
            '{OP_WRITE, 4'd1,  10'd0,    10'd0,    16'd3,      1'b0, NO_BOUNDS},
            '{OP_QUERY, 4'd0,  10'd0,    10'd1023, 16'd0,      1'b0, NO_BOUNDS},
            '{OP_WRITE, 4'd2,  10'd1023, 10'd0,    16'd1,      1'b0, NO_BOUNDS},
            '{OP_QUERY, 4'd5,  10'd1023, 10'd0,    16'h1234,   1'b0, NO_BOUNDS},
            '{OP_WRITE, 4'd3,  10'd0,    10'd0,    16'h8000,   1'b0, NO_BOUNDS},
            '{OP_QUERY, 4'd0,  10'd0,    10'd0,    16'd0,      1'b0, NO_BOUNDS},
            '{OP_QUERY, 4'd10, 10'd0,    10'd1023, 16'hFFFF,   1'b0, NO_BOUNDS}
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
            send_beat(dir_tab[r]);

        for (int p = 0; p < PHASES; p++)
        begin
            count = (p < FIXED_PHASES) ? FIXED_COUNTS[p] : COUNT_BITS'($urandom_range(0, 31));
            wait_drained();
            repeat (SETTLE_CYCLES) @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_wdata <= count;
            @(posedge clk);
            cfg_we <= 1'b0;
            lm_count_shadow = count;
            run_phase(PHASE_ITEMS);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_bounds.size() == 0)
            $display("PASS landmark_distance_bound_query_top");
        else
            $display("FAIL landmark_distance_bound_query_top");
        $finish;
    end

    initial begin
        rx_mode_t mode;
        bit       rdy;
        bit       hold;
        int       span;
        int       run;
        result_ch.ready <= 1'b0;
        hold = 1'b1;
        run  = 0;
        forever
        begin
            mode = rx_mode_t'($urandom_range(0, 3));
            span = $urandom_range(20, 300);
            repeat (span)
            begin
                @(posedge clk);
                case (mode)
                    RX_STEADY: rdy = 1'b1;
                    RX_COIN:   rdy = $urandom_range(0, 1);
                    RX_MOSTLY: rdy = ($urandom_range(0, 7) != 0);
                    default:
                    begin
                        if (run == 0)
                        begin
                            hold = !hold;
                            run  = hold ? $urandom_range(1, 12) : $urandom_range(5, 40);
                        end
                        run--;
                        rdy = hold;
                    end
                endcase
                result_ch.ready <= rdy;
            end
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got = '{result_ch.upper_bound, result_ch.lower_bound, result_ch.midpoint,
                    result_ch.geometric_mean, result_ch.upper_found};
            if (pending_bounds.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: result beat with no query waiting: upper %0d lower %0d",
                             $realtime, got.upper, got.lower);
            end
            else
            begin
                want = pending_bounds.pop_front();
                if (got.upper !== want.upper || got.lower !== want.lower ||
                    got.mid !== want.mid || got.gmean !== want.gmean ||
                    got.found !== want.found)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display({"%0t: bounds mismatch (expected/actual): upper %0d/%0d ",
                                  "lower %0d/%0d mid %0d/%0d gmean %0d/%0d found %0b/%0b"},
                                 $realtime, want.upper, got.upper, want.lower, got.lower,
                                 want.mid, got.mid, want.gmean, got.gmean,
                                 want.found, got.found);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("FAIL landmark_distance_bound_query_top");
                $finish;
            end
        end
    end

endmodule
